/* rtl/dq_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the double-ended queue.
// Used by dq_ctrl, dq_datapath and double_ended_queue; depends on nothing.

package dq_pkg;

    localparam int CAPACITY = 1024;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int WORD_W   = 32;
    localparam int OCC_W    = 11;
    localparam int OP_W     = 2;
    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 48;
    localparam int TUSER_OUT_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_TOP = 2'd0,
        OP_POP_TOP  = 2'd1,
        OP_PUSH_BOT = 2'd2,
        OP_POP_BOT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_HOLD = 2'b10
    } t_state;

    // Commands from the controller; at most one of the four moves is set.
    typedef struct packed {
        logic load;
        logic push_top;
        logic pop_top;
        logic push_bot;
        logic pop_bot;
        logic err_empty;
        logic err_full;
    } t_dp_cmd;

    typedef struct packed {
        logic is_full;
        logic is_empty;
    } t_dp_status;

endpackage

/* rtl/double_ended_queue.sv */
`timescale 1ns / 1ps
// Top level of the double-ended queue: ties the controller to the datapath.
// Depends on dq_pkg, dq_ctrl and dq_datapath.

// A deque of 1024 signed 32-bit words held in a single-port circular store.
// Each input beat carries an op in tuser (push top, pop top, push bottom,
// pop bottom) and a word in tdata; each one yields exactly one result beat,
// in the cycle after it is taken, with the popped word (-1 for a pop from an
// empty queue, 0 for a push), the two error flags and the occupancy after the
// step. The block takes one beat per cycle: every op needs one pointer update
// and one access to the store, and a new beat is taken in the same cycle that
// the previous result is taken downstream. Nothing needs clearing after reset.

module double_ended_queue (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [dq_pkg::TDATA_IN_W-1:0]    i_s_tdata,   // [31:0] data_in
    input  logic [dq_pkg::OP_W-1:0]          i_s_tuser,   // [1:0] op
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [31:0] data_out, [42:32] occupancy, [47:43] zero
    output logic [dq_pkg::TDATA_OUT_W-1:0]   o_m_tdata,
    output logic [dq_pkg::TUSER_OUT_W-1:0]   o_m_tuser    // [0] empty_error, [1] full_error
);

    dq_pkg::t_dp_cmd    w_cmd;
    dq_pkg::t_dp_status w_status;
    dq_pkg::t_op        w_op;
    logic signed [dq_pkg::WORD_W-1:0] w_data_out;
    logic                             w_empty_err;
    logic                             w_full_err;
    logic [dq_pkg::OCC_W-1:0]         w_occ;

    assign w_op = dq_pkg::t_op'(i_s_tuser);

    dq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_m_tready (i_m_tready),
        .i_op       (w_op),
        .i_status   (w_status),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_cmd      (w_cmd)
    );

    dq_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_data      (i_s_tdata),
        .o_status    (w_status),
        .o_data      (w_data_out),
        .o_empty_err (w_empty_err),
        .o_full_err  (w_full_err),
        .o_occ       (w_occ)
    );

    assign o_m_tdata = {5'b0, w_occ, w_data_out};
    assign o_m_tuser = {w_full_err, w_empty_err};

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> o_m_tvalid)
        else $error("accepted beat produced no result");

    a_empty_pop_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[31:0] == 32'hFFFF_FFFF
                                          && o_m_tdata[42:32] == '0))
        else $error("empty pop must return -1 with zero occupancy");

    a_full_push_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (o_m_tdata[42:32] == dq_pkg::OCC_W'(dq_pkg::CAPACITY)
                                          && o_m_tdata[31:0] == '0))
        else $error("dropped push must report a full queue and zero data");

    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("empty and full errors raised together");

endmodule

/* rtl/dq_ctrl.sv */
`timescale 1ns / 1ps
// Controller of the double-ended queue: handshake state machine and op decode.
// Depends on dq_pkg.

module dq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    input  logic               i_m_tready,
    input  dq_pkg::t_op        i_op,
    input  dq_pkg::t_dp_status i_status,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    output dq_pkg::t_dp_cmd    o_cmd
);

    dq_pkg::t_state r_state;
    dq_pkg::t_state n_state;
    logic           w_accept;

    // A new beat is taken whenever the result slot is free or being emptied.
    always_comb begin
        unique case (r_state)
            dq_pkg::S_IDLE: o_s_tready = 1'b1;
            dq_pkg::S_HOLD: o_s_tready = i_m_tready;
            default:        o_s_tready = 1'b0;
        endcase
    end

    assign o_m_tvalid = (r_state == dq_pkg::S_HOLD);
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dq_pkg::S_IDLE: begin
                if (w_accept) n_state = dq_pkg::S_HOLD;
            end
            dq_pkg::S_HOLD: begin
                if (w_accept)        n_state = dq_pkg::S_HOLD;
                else if (i_m_tready) n_state = dq_pkg::S_IDLE;
            end
            default: n_state = dq_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.load = w_accept;
        unique case (i_op)
            dq_pkg::OP_PUSH_TOP: begin
                o_cmd.push_top = w_accept && !i_status.is_full;
                o_cmd.err_full = i_status.is_full;
            end
            dq_pkg::OP_POP_TOP: begin
                o_cmd.pop_top   = w_accept && !i_status.is_empty;
                o_cmd.err_empty = i_status.is_empty;
            end
            dq_pkg::OP_PUSH_BOT: begin
                o_cmd.push_bot = w_accept && !i_status.is_full;
                o_cmd.err_full = i_status.is_full;
            end
            dq_pkg::OP_POP_BOT: begin
                o_cmd.pop_bot   = w_accept && !i_status.is_empty;
                o_cmd.err_empty = i_status.is_empty;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

/* rtl/dq_datapath.sv */
`timescale 1ns / 1ps
// Datapath of the double-ended queue: word store, end pointers, count, result register.
// Depends on dq_pkg; driven by commands from dq_ctrl.

module dq_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dq_pkg::t_dp_cmd                   i_cmd,
    input  logic signed [dq_pkg::WORD_W-1:0]  i_data,
    output dq_pkg::t_dp_status                o_status,
    output logic signed [dq_pkg::WORD_W-1:0]  o_data,
    output logic                              o_empty_err,
    output logic                              o_full_err,
    output logic [dq_pkg::OCC_W-1:0]          o_occ
);

    logic [dq_pkg::WORD_W-1:0] r_mem [dq_pkg::CAPACITY];

    logic [dq_pkg::IDX_W-1:0] r_top;
    logic [dq_pkg::IDX_W-1:0] r_bot;
    logic [dq_pkg::CNT_W-1:0] r_count;
    logic [dq_pkg::IDX_W-1:0] n_top;
    logic [dq_pkg::IDX_W-1:0] n_bot;
    logic [dq_pkg::CNT_W-1:0] n_count;

    logic [dq_pkg::IDX_W-1:0] w_top_inc;
    logic [dq_pkg::IDX_W-1:0] w_top_dec;
    logic [dq_pkg::IDX_W-1:0] w_bot_inc;
    logic [dq_pkg::IDX_W-1:0] w_bot_dec;
    logic [dq_pkg::IDX_W-1:0] w_addr;
    logic                     w_wr;
    logic                     w_rd;

    logic [dq_pkg::WORD_W-1:0] r_rd_data;
    logic                      r_sel_rd;
    logic                      r_empty_err;
    logic                      r_full_err;
    logic [dq_pkg::OCC_W-1:0]  r_occ;

    localparam logic [dq_pkg::IDX_W-1:0] LAST_IDX = dq_pkg::IDX_W'(dq_pkg::CAPACITY - 1);

    assign w_top_inc = (r_top == LAST_IDX) ? '0 : r_top + dq_pkg::IDX_W'(1);
    assign w_top_dec = (r_top == '0) ? LAST_IDX : r_top - dq_pkg::IDX_W'(1);
    assign w_bot_inc = (r_bot == LAST_IDX) ? '0 : r_bot + dq_pkg::IDX_W'(1);
    assign w_bot_dec = (r_bot == '0) ? LAST_IDX : r_bot - dq_pkg::IDX_W'(1);

    assign o_status.is_full  = (r_count == dq_pkg::CNT_W'(dq_pkg::CAPACITY));
    assign o_status.is_empty = (r_count == '0);

    assign w_wr = i_cmd.push_top || i_cmd.push_bot;
    assign w_rd = i_cmd.pop_top || i_cmd.pop_bot;

    // The top pointer sits one past the top word; the bottom pointer on the bottom word.
    always_comb begin
        n_top   = r_top;
        n_bot   = r_bot;
        n_count = r_count;
        w_addr  = r_top;
        if (i_cmd.push_top) begin
            w_addr  = r_top;
            n_top   = w_top_inc;
            n_count = r_count + dq_pkg::CNT_W'(1);
        end else if (i_cmd.pop_top) begin
            w_addr  = w_top_dec;
            n_top   = w_top_dec;
            n_count = r_count - dq_pkg::CNT_W'(1);
        end else if (i_cmd.push_bot) begin
            w_addr  = w_bot_dec;
            n_bot   = w_bot_dec;
            n_count = r_count + dq_pkg::CNT_W'(1);
        end else if (i_cmd.pop_bot) begin
            w_addr  = r_bot;
            n_bot   = w_bot_inc;
            n_count = r_count - dq_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top   <= '0;
            r_bot   <= '0;
            r_count <= '0;
        end else begin
            r_top   <= n_top;
            r_bot   <= n_bot;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[w_addr] <= i_data;
        end
        if (w_rd) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sel_rd    <= w_rd;
            r_empty_err <= i_cmd.err_empty;
            r_full_err  <= i_cmd.err_full;
            r_occ       <= dq_pkg::OCC_W'(n_count);
        end
    end

    always_comb begin
        if (r_empty_err)   o_data = '1;
        else if (r_sel_rd) o_data = r_rd_data;
        else               o_data = '0;
    end

    assign o_empty_err = r_empty_err;
    assign o_full_err  = r_full_err;
    assign o_occ       = r_occ;

endmodule
